// ----- src/tal_pkg.sv -----
// Shared types and constants for the Thumb ALU with flags.
`timescale 1ns / 1ps

package tal_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_LSL = 4'd2,
    OP_LSR = 4'd3,
    OP_ASR = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_ROR = 4'd7,
    OP_TST = 4'd8,
    OP_NEG = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MUL = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } op_t;

  localparam int unsigned DataW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned CycW  = 3;

  typedef struct packed {
    op_t              op;
    logic [DataW-1:0] dest_value;
    logic [DataW-1:0] source_value;
    logic             carry_in;
    logic             overflow_in;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             write_back;
    logic             flag_n;
    logic             flag_z;
    logic             flag_c;
    logic             flag_v;
    logic [CycW-1:0]  extra_cycles;
  } res_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_out_t;

endpackage

// ----- src/tal_shift.sv -----
// Barrel shifter for the register shifts and rotate, with ARM carry rules.
`timescale 1ns / 1ps

module tal_shift (
  input  tal_pkg::op_t                op,
  input  logic [tal_pkg::DataW-1:0]   value,
  input  logic [7:0]                  amount,
  input  logic                        carry_in,
  output tal_pkg::shift_out_t         shifted
);
  import tal_pkg::*;

  logic [4:0]           k;
  logic                 zero_amt;
  logic                 big_amt;
  logic                 eq32;
  logic [DataW:0]       lsl_w;
  logic [DataW:0]       lsr_w;
  logic signed [DataW:0] asr_w;
  logic [2*DataW-1:0]   rot_w;

  assign k        = amount[4:0];
  assign zero_amt = (amount == 8'd0);
  assign big_amt  = (amount[7:5] != 3'd0);
  assign eq32     = (amount == 8'd32);
  assign lsl_w    = {1'b0, value} << k;
  assign lsr_w    = {value, 1'b0} >> k;
  assign asr_w    = $signed({value, 1'b0}) >>> k;
  assign rot_w    = {value, value} >> k;

  always_comb begin
    shifted.value = value;
    shifted.carry = carry_in;
    if (!zero_amt) begin
      case (op)
        OP_LSL: begin
          if (!big_amt) begin
            shifted.value = lsl_w[DataW-1:0];
            shifted.carry = lsl_w[DataW];
          end else begin
            shifted.value = '0;
            shifted.carry = eq32 & value[0];
          end
        end
        OP_LSR: begin
          if (!big_amt) begin
            shifted.value = lsr_w[DataW:1];
            shifted.carry = lsr_w[0];
          end else begin
            shifted.value = '0;
            shifted.carry = eq32 & value[DataW-1];
          end
        end
        OP_ASR: begin
          if (!big_amt) begin
            shifted.value = asr_w[DataW:1];
            shifted.carry = asr_w[0];
          end else begin
            shifted.value = {DataW{value[DataW-1]}};
            shifted.carry = value[DataW-1];
          end
        end
        OP_ROR: begin
          shifted.value = rot_w[DataW-1:0];
          shifted.carry = rot_w[DataW-1];
        end
        default: begin
          shifted.value = value;
          shifted.carry = carry_in;
        end
      endcase
    end
  end

endmodule

// ----- src/thumb_alu_with_flags.sv -----
// Top level of the pipelined Thumb ALU with flag generation.
// A request is registered in s1, then s2, s3 and s4; res and res_valid come from s4.
// Throughput is one request per cycle while res_ready is high; stages advance independently, so bubbles close up.
// The multiply is split into 16-bit partial products in stage two and summed in stage three.
// Synchronous active-high reset clears all stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module thumb_alu_with_flags (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tal_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output tal_pkg::res_t res
);
  import tal_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] pp_ll;
    logic [HalfW-1:0] pp_hl;
    logic [HalfW-1:0] pp_lh;
    logic             is_mul;
    logic             carry;
    logic             overflow;
    logic             write_back;
    logic [CycW-1:0]  cycles;
  } stage2_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
    logic             overflow;
    logic             write_back;
    logic [CycW-1:0]  cycles;
  } stage3_t;

  logic    v1, v2, v3, v4;
  logic    en1, en2, en3, en4;
  req_t    s1;
  stage2_t s2, s2_next;
  stage3_t s3, s3_next;
  res_t    s4, s4_next;

  assign en4       = !v4 || res_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign res_valid = v4;
  assign res       = s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= req;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
  end

  shift_out_t shifted;

  tal_shift u_shift (
    .op      (s1.op),
    .value   (s1.dest_value),
    .amount  (s1.source_value[7:0]),
    .carry_in(s1.carry_in),
    .shifted (shifted)
  );

  logic [DataW-1:0] add_a, add_b, add_r;
  logic             add_cin;
  logic [DataW:0]   add_w;
  logic             add_v;
  logic [HalfW-1:0] prod_hl, prod_lh;
  logic [DataW-1:0] prod_ll;
  logic [CycW-1:0]  mul_cyc;
  logic [23:0]      top24;
  logic [15:0]      top16;
  logic [7:0]       top8;

  always_comb begin
    add_a   = s1.dest_value;
    add_b   = s1.source_value;
    add_cin = s1.carry_in;
    case (s1.op)
      OP_ADC: begin
        add_b   = s1.source_value;
        add_cin = s1.carry_in;
      end
      OP_SBC: begin
        add_b   = ~s1.source_value;
        add_cin = s1.carry_in;
      end
      OP_NEG: begin
        add_a   = '0;
        add_b   = ~s1.source_value;
        add_cin = 1'b1;
      end
      OP_CMP: begin
        add_b   = ~s1.source_value;
        add_cin = 1'b1;
      end
      OP_CMN: begin
        add_cin = 1'b0;
      end
      default: begin
        add_b   = s1.source_value;
        add_cin = s1.carry_in;
      end
    endcase
  end

  assign add_w = {1'b0, add_a} + {1'b0, add_b} + {{DataW{1'b0}}, add_cin};
  assign add_r = add_w[DataW-1:0];
  assign add_v = ~(add_a[DataW-1] ^ add_b[DataW-1]) & (add_a[DataW-1] ^ add_r[DataW-1]);

  assign prod_ll = {{HalfW{1'b0}}, s1.dest_value[HalfW-1:0]}
                 * {{HalfW{1'b0}}, s1.source_value[HalfW-1:0]};
  assign prod_hl = s1.dest_value[DataW-1:HalfW] * s1.source_value[HalfW-1:0];
  assign prod_lh = s1.dest_value[HalfW-1:0] * s1.source_value[DataW-1:HalfW];

  assign top24 = s1.dest_value[31:8];
  assign top16 = s1.dest_value[31:16];
  assign top8  = s1.dest_value[31:24];
  assign mul_cyc = CycW'(3'd1)
                 + CycW'((top24 != 24'h000000) && (top24 != 24'hffffff))
                 + CycW'((top16 != 16'h0000) && (top16 != 16'hffff))
                 + CycW'((top8 != 8'h00) && (top8 != 8'hff));

  always_comb begin
    s2_next.value      = s1.dest_value & s1.source_value;
    s2_next.pp_ll      = prod_ll;
    s2_next.pp_hl      = prod_hl;
    s2_next.pp_lh      = prod_lh;
    s2_next.is_mul     = 1'b0;
    s2_next.carry      = s1.carry_in;
    s2_next.overflow   = s1.overflow_in;
    s2_next.write_back = 1'b1;
    s2_next.cycles     = '0;
    case (s1.op)
      OP_AND: s2_next.value = s1.dest_value & s1.source_value;
      OP_EOR: s2_next.value = s1.dest_value ^ s1.source_value;
      OP_ORR: s2_next.value = s1.dest_value | s1.source_value;
      OP_BIC: s2_next.value = s1.dest_value & ~s1.source_value;
      OP_MVN: s2_next.value = ~s1.source_value;
      OP_TST: begin
        s2_next.value      = s1.dest_value & s1.source_value;
        s2_next.write_back = 1'b0;
      end
      OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
        s2_next.value  = shifted.value;
        s2_next.carry  = shifted.carry;
        s2_next.cycles = CycW'(3'd1);
      end
      OP_ADC, OP_SBC, OP_NEG, OP_CMP, OP_CMN: begin
        s2_next.value      = add_r;
        s2_next.carry      = add_w[DataW];
        s2_next.overflow   = add_v;
        s2_next.write_back = !((s1.op == OP_CMP) || (s1.op == OP_CMN));
      end
      OP_MUL: begin
        s2_next.is_mul = 1'b1;
        s2_next.cycles = mul_cyc;
      end
      default: s2_next.value = s1.dest_value & s1.source_value;
    endcase
  end

  logic [HalfW-1:0] cross_sum;

  assign cross_sum = s2.pp_hl + s2.pp_lh;

  always_comb begin
    s3_next.value      = s2.is_mul ? (s2.pp_ll + {cross_sum, {HalfW{1'b0}}}) : s2.value;
    s3_next.carry      = s2.carry;
    s3_next.overflow   = s2.overflow;
    s3_next.write_back = s2.write_back;
    s3_next.cycles     = s2.cycles;
  end

  always_comb begin
    s4_next.result       = s3.value;
    s4_next.write_back   = s3.write_back;
    s4_next.flag_n       = s3.value[DataW-1];
    s4_next.flag_z       = (s3.value == '0);
    s4_next.flag_c       = s3.carry;
    s4_next.flag_v       = s3.overflow;
    s4_next.extra_cycles = s3.cycles;
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the Thumb ALU with flags: random and directed requests, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import tal_pkg::*;

  localparam int RandomItems = 1200;
  localparam int QuietTail = 200;
  localparam int HoldAt = 400;
  localparam int HoldCycles = 200;
  localparam int DrainCycles = 20;
  localparam int StallLimit = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  req_t pending_requests[$];
  res_t expected_results[$];
  int error_count = 0;
  int results_seen = 0;
  int send_gap = 0;
  int sink_stall = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  thumb_alu_with_flags u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] add_with_carry(input logic [31:0] x, input logic [31:0] y,
                                                 input logic cin, output logic cout,
                                                 output logic ovf);
    logic [32:0] wide;
    wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
    cout = wide[32];
    ovf = ~(x[31] ^ y[31]) & (x[31] ^ wide[31]);
    return wide[31:0];
  endfunction

  function automatic res_t predict_alu(req_t r);
    res_t o;
    logic [31:0] a, b, val;
    logic c, v, wb;
    logic [2:0] cyc;
    int n, k;
    a = r.dest_value;
    b = r.source_value;
    n = int'(b[7:0]);
    c = r.carry_in;
    v = r.overflow_in;
    wb = 1'b1;
    cyc = '0;
    val = '0;
    case (r.op)
      OP_AND: val = a & b;
      OP_EOR: val = a ^ b;
      OP_LSL: begin
        cyc = 3'd1;
        if (n == 0) begin
          val = a;
        end else if (n < 32) begin
          c = a[32 - n];
          val = a << n;
        end else begin
          c = (n == 32) ? a[0] : 1'b0;
          val = '0;
        end
      end
      OP_LSR: begin
        cyc = 3'd1;
        if (n == 0) begin
          val = a;
        end else if (n < 32) begin
          c = a[n - 1];
          val = a >> n;
        end else begin
          c = (n == 32) ? a[31] : 1'b0;
          val = '0;
        end
      end
      OP_ASR: begin
        cyc = 3'd1;
        if (n == 0) begin
          val = a;
        end else if (n < 32) begin
          c = a[n - 1];
          val = $signed(a) >>> n;
        end else begin
          c = a[31];
          val = {32{a[31]}};
        end
      end
      OP_ADC: val = add_with_carry(a, b, c, c, v);
      OP_SBC: val = add_with_carry(a, ~b, c, c, v);
      OP_ROR: begin
        cyc = 3'd1;
        if (n == 0) begin
          val = a;
        end else begin
          k = n % 32;
          val = (k == 0) ? a : ((a >> k) | (a << (32 - k)));
          c = val[31];
        end
      end
      OP_TST: begin
        val = a & b;
        wb = 1'b0;
      end
      OP_NEG: val = add_with_carry(32'd0, ~b, 1'b1, c, v);
      OP_CMP: begin
        val = add_with_carry(a, ~b, 1'b1, c, v);
        wb = 1'b0;
      end
      OP_CMN: begin
        val = add_with_carry(a, b, 1'b0, c, v);
        wb = 1'b0;
      end
      OP_ORR: val = a | b;
      OP_MUL: begin
        cyc = 3'd1;
        if (a[31:8] != 24'h0 && a[31:8] != 24'hffffff) cyc = cyc + 3'd1;
        if (a[31:16] != 16'h0 && a[31:16] != 16'hffff) cyc = cyc + 3'd1;
        if (a[31:24] != 8'h0 && a[31:24] != 8'hff) cyc = cyc + 3'd1;
        val = a * b;
      end
      OP_BIC: val = a & ~b;
      OP_MVN: val = ~b;
      default: val = '0;
    endcase
    o.result = val;
    o.write_back = wb;
    o.flag_n = val[31];
    o.flag_z = (val == 32'd0);
    o.flag_c = c;
    o.flag_v = v;
    o.extra_cycles = cyc;
    return o;
  endfunction

  task automatic queue_request(op_t op, logic [31:0] d, logic [31:0] s, logic c, logic v);
    req_t r;
    r.op = op;
    r.dest_value = d;
    r.source_value = s;
    r.carry_in = c;
    r.overflow_in = v;
    pending_requests.push_back(r);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] raw;
    int sh;
    raw = $urandom;
    sh = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 255);
      5, 6: return $signed(raw << sh) >>> sh;
      default: return raw;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift_source();
    logic [31:0] upper;
    logic [7:0] amount;
    upper = $urandom_range(0, 1) ? $urandom : 32'd0;
    case ($urandom_range(0, 5))
      0: amount = 8'(32 * $urandom_range(0, 7));
      1: amount = 8'($urandom_range(0, 255));
      2: amount = 8'($urandom_range(30, 34));
      default: amount = 8'($urandom_range(0, 40));
    endcase
    return {upper[31:8], amount};
  endfunction

  task automatic report_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d field %s: got %h, expected %h",
                             results_seen, name, got, want));
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ready) expected_results.push_back(predict_alu(req));
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req <= pending_requests.pop_front();
          req_valid <= 1'b1;
          if (pending_requests.size() > QuietTail && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 12);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result %h", res));
        end else begin
          want = expected_results.pop_front();
          check_field("result", res.result, want.result);
          check_field("write_back", 32'(res.write_back), 32'(want.write_back));
          check_field("flag_n", 32'(res.flag_n), 32'(want.flag_n));
          check_field("flag_z", 32'(res.flag_z), 32'(want.flag_z));
          check_field("flag_c", 32'(res.flag_c), 32'(want.flag_c));
          check_field("flag_v", 32'(res.flag_v), 32'(want.flag_v));
          check_field("extra_cycles", 32'(res.extra_cycles), 32'(want.extra_cycles));
        end
        results_seen++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        sink_stall = HoldCycles - 1;
        res_ready <= 1'b0;
      end else if (pending_requests.size() > QuietTail && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 12) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no handshake for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    op_t op;
    logic [31:0] d, s;
    queue_request(OP_AND, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1);
    queue_request(OP_EOR, 32'hffff_ffff, 32'h0f0f_0f0f, 1'b0, 1'b0);
    queue_request(OP_LSL, 32'h8000_0001, 32'h0000_0000, 1'b1, 1'b0);
    queue_request(OP_LSL, 32'h8000_0001, 32'h0000_0001, 1'b0, 1'b1);
    queue_request(OP_LSL, 32'h0000_0001, 32'h0000_001f, 1'b1, 1'b0);
    queue_request(OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0, 1'b0);
    queue_request(OP_LSL, 32'h1234_5678, 32'hffff_ff00, 1'b1, 1'b1);
    queue_request(OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0);
    queue_request(OP_LSR, 32'hffff_ffff, 32'h0000_00c8, 1'b1, 1'b0);
    queue_request(OP_ASR, 32'h8000_0000, 32'h0000_0005, 1'b0, 1'b1);
    queue_request(OP_ASR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0);
    queue_request(OP_ASR, 32'h7fff_ffff, 32'h0000_00ff, 1'b1, 1'b0);
    queue_request(OP_ADC, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    queue_request(OP_ADC, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1);
    queue_request(OP_SBC, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    queue_request(OP_SBC, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0);
    queue_request(OP_ROR, 32'h8000_0001, 32'h0000_0040, 1'b0, 1'b1);
    queue_request(OP_TST, 32'h0000_00f0, 32'h0000_000f, 1'b1, 1'b0);
    queue_request(OP_NEG, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1);
    queue_request(OP_NEG, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0);
    queue_request(OP_CMP, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b1);
    queue_request(OP_CMN, 32'hffff_ffff, 32'h0000_0001, 1'b0, 1'b0);
    queue_request(OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    queue_request(OP_MUL, 32'h1234_5678, 32'h0000_0009, 1'b1, 1'b1);
    queue_request(OP_MUL, 32'hffff_ff80, 32'h0000_0003, 1'b0, 1'b0);
    queue_request(OP_BIC, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    queue_request(OP_MVN, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
    for (int i = 0; i < RandomItems; i++) begin
      op = op_t'($urandom_range(0, 15));
      d = pick_operand();
      if ((op == OP_LSL || op == OP_LSR || op == OP_ASR || op == OP_ROR) &&
          $urandom_range(0, 3) != 0) begin
        s = pick_shift_source();
      end else begin
        s = pick_operand();
      end
      queue_request(op, d, s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tal_pkg.sv
src/tal_shift.sv
src/thumb_alu_with_flags.sv
dv/testbench.sv
